@@ src/urb_pkg.sv @@
package urb_pkg;

  // Default ring depths.
  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam int unsigned TX_DEPTH_DEF = 64;

  // Fixed field widths of the channels.
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 6;

  // Item operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_RX_BYTE    = 2'd0,
    MODE_HOST_READ  = 2'd1,
    MODE_HOST_WRITE = 2'd2,
    MODE_TX_EMPTY   = 2'd3
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic is_read;
    logic take_zero;
    logic last_step;
  } dp_status_t;

endpackage

@@ src/urb_req_if.sv @@
interface urb_req_if;
  logic                         valid;
  logic                         ready;
  logic [urb_pkg::MODE_W-1:0]   mode;
  logic [urb_pkg::BYTE_W-1:0]   byte_in;
  logic [urb_pkg::COUNT_W-1:0]  read_count;

  modport source (output valid, mode, byte_in, read_count, input ready);
  modport sink (input valid, mode, byte_in, read_count, output ready);
endinterface

@@ src/urb_rsp_if.sv @@
interface urb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [urb_pkg::BYTE_W-1:0]   read_byte;
  logic                         read_valid;
  logic                         last;
  logic [urb_pkg::BYTE_W-1:0]   line_byte;
  logic                         line_valid;
  logic                         write_accepted;
  logic [urb_pkg::COUNT_W-1:0]  rx_available;

  modport source (output valid, read_byte, read_valid, last, line_byte, line_valid,
                  write_accepted, rx_available, input ready);
  modport sink (input valid, read_byte, read_valid, last, line_byte, line_valid,
                write_accepted, rx_available, output ready);
endinterface

@@ src/uart_rx_tx_ring_buffers.sv @@
// Receive and transmit byte rings for a UART, driven by one request channel.
// Each req beat carries mode, byte_in and read_count: a received line byte
// (stored, or dropped when the receive ring is full), a host read of up to
// read_count bytes, a host write (queued, or rejected when the transmit ring
// is full), or a transmitter-empty event that sends the next queued byte, if any.
// Each ring holds one byte fewer than its depth.
// The rsp channel returns one beat per request, or one beat per byte for a
// host read; last marks the final beat of a request and rx_available gives
// the receive fill after the whole request.
// The req beat is latched, the item is executed in the EXEC state once the
// output register is free, and its rsp beat is registered; a host read that
// takes bytes registers its first beat in the BURST state instead, one byte
// per cycle from the receive store's read port while rsp is not stalled.
// A new request is taken while the last rsp beat still waits in the output
// register. When rsp is stalled, the block holds its beat and stops.
// Reset empties both rings and makes the transmitter idle; no clearing pass
// is needed, and ready is already high when reset is released.
module uart_rx_tx_ring_buffers #(
  parameter int unsigned RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  urb_req_if.sink   req,
  urb_rsp_if.source rsp
);

  urb_pkg::ctrl_cmd_t  cmd;
  urb_pkg::dp_status_t status;

  // Sequencing of each request.
  urb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Rings, stores and the output register.
  urb_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .in_mode            (req.mode),
    .in_byte            (req.byte_in),
    .in_count           (req.read_count),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .out_read_byte      (rsp.read_byte),
    .out_read_valid     (rsp.read_valid),
    .out_last           (rsp.last),
    .out_line_byte      (rsp.line_byte),
    .out_line_valid     (rsp.line_valid),
    .out_write_accepted (rsp.write_accepted),
    .out_rx_available   (rsp.rx_available)
  );

`ifndef SYNTHESIS
  // A request is worked on alone: ready drops right after an accepted beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while the previous one is in work");

  // The reported receive fill never reaches the ring depth.
  a_rx_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.rx_available <= urb_pkg::COUNT_W'(RX_DEPTH - 1)))
    else $error("receive fill beyond ring capacity");

  // A beat never carries both a host byte and a line byte.
  a_one_byte_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.read_valid && rsp.line_valid))
    else $error("read byte and line byte on the same beat");

  // Only a transmit action can send a byte; this checks it is on a final beat, never mid burst.
  a_line_not_with_partial: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.line_valid) |-> rsp.last)
    else $error("line byte on a beat that is not final");
`endif

endmodule

@@ src/urb_ctrl.sv @@
module urb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  urb_pkg::dp_status_t status,
  output urb_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BURST
  } state_t;

  state_t state;

  // Commands follow the current state; the datapath executes and steps only when
  // its output register can take a beat.
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == ST_EXEC) && status.out_free;
  assign cmd.step = (state == ST_BURST) && status.out_free;

  // State register with a registered ready that is high only in idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_EXEC;
            in_ready <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (status.out_free) begin
            if (status.is_read && !status.take_zero) begin
              state <= ST_BURST;
            end else begin
              state    <= ST_IDLE;
              in_ready <= 1'b1;
            end
          end
        end
        ST_BURST: begin
          if (status.out_free && status.last_step) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ src/urb_datapath.sv @@
module urb_datapath #(
  parameter int unsigned RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  urb_pkg::ctrl_cmd_t           cmd,
  output urb_pkg::dp_status_t          status,
  input  logic [urb_pkg::MODE_W-1:0]   in_mode,
  input  logic [urb_pkg::BYTE_W-1:0]   in_byte,
  input  logic [urb_pkg::COUNT_W-1:0]  in_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [urb_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                         out_read_valid,
  output logic                         out_last,
  output logic [urb_pkg::BYTE_W-1:0]   out_line_byte,
  output logic                         out_line_valid,
  output logic                         out_write_accepted,
  output logic [urb_pkg::COUNT_W-1:0]  out_rx_available
);

  localparam int unsigned RX_PTR_W = $clog2(RX_DEPTH);
  localparam int unsigned TX_PTR_W = $clog2(TX_DEPTH);
  localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
  localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

  // Latched item.
  urb_pkg::mode_t               item_mode;
  logic [urb_pkg::BYTE_W-1:0]   item_byte;
  logic [urb_pkg::COUNT_W-1:0]  item_count;

  // Ring state; rx_cnt holds the number of bytes waiting.
  logic [RX_PTR_W-1:0]          rx_wptr, rx_wptr_next, rx_rptr, rx_rptr_next;
  logic [RX_PTR_W-1:0]          rx_cnt, rx_cnt_next;
  logic [TX_PTR_W-1:0]          tx_wptr, tx_wptr_next, tx_rptr, tx_rptr_next;
  logic                         tx_active, tx_active_next;
  logic [urb_pkg::COUNT_W-1:0]  left, left_next;

  // Byte stores with registered read data.
  logic [urb_pkg::BYTE_W-1:0]   rx_mem [RX_DEPTH];
  logic [urb_pkg::BYTE_W-1:0]   tx_mem [TX_DEPTH];
  logic [urb_pkg::BYTE_W-1:0]   rx_q, tx_q;
  logic                         rx_we, tx_we;

  // Next values for the output register.
  logic                         load_out;
  logic [urb_pkg::BYTE_W-1:0]   rb_next, lb_next;
  logic                         rv_next, last_next, lv_next, wa_next;

  // Pointer increments with wrap at the ring depth.
  logic [RX_PTR_W-1:0]          rx_wptr_inc, rx_rptr_inc;
  logic [TX_PTR_W-1:0]          tx_wptr_inc, tx_rptr_inc;
  logic [urb_pkg::COUNT_W-1:0]  avail6, take6;

  assign rx_wptr_inc = (rx_wptr == RX_LAST) ? '0 : rx_wptr + RX_PTR_W'(1);
  assign rx_rptr_inc = (rx_rptr == RX_LAST) ? '0 : rx_rptr + RX_PTR_W'(1);
  assign tx_wptr_inc = (tx_wptr == TX_LAST) ? '0 : tx_wptr + TX_PTR_W'(1);
  assign tx_rptr_inc = (tx_rptr == TX_LAST) ? '0 : tx_rptr + TX_PTR_W'(1);

  // Bytes a host read takes: the smaller of the request and the fill.
  assign avail6 = urb_pkg::COUNT_W'(rx_cnt);
  assign take6  = (item_count < avail6) ? item_count : avail6;

  // Status toward the controller.
  assign status.out_free  = !out_valid || out_ready;
  assign status.is_read   = (item_mode == urb_pkg::MODE_HOST_READ);
  assign status.take_zero = (take6 == '0);
  assign status.last_step = (left == urb_pkg::COUNT_W'(1));

  // Per-item operation and burst step.
  always_comb begin
    rx_wptr_next   = rx_wptr;
    rx_rptr_next   = rx_rptr;
    rx_cnt_next    = rx_cnt;
    tx_wptr_next   = tx_wptr;
    tx_rptr_next   = tx_rptr;
    tx_active_next = tx_active;
    left_next      = left;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    load_out       = 1'b0;
    rb_next        = '0;
    rv_next        = 1'b0;
    last_next      = 1'b1;
    lb_next        = '0;
    lv_next        = 1'b0;
    wa_next        = 1'b0;
    if (cmd.exec) begin
      unique case (item_mode)
        urb_pkg::MODE_RX_BYTE: begin
          load_out = 1'b1;
          if (rx_cnt != RX_LAST) begin
            rx_we        = 1'b1;
            rx_wptr_next = rx_wptr_inc;
            rx_cnt_next  = rx_cnt + RX_PTR_W'(1);
          end
        end
        urb_pkg::MODE_HOST_READ: begin
          rx_cnt_next = RX_PTR_W'(avail6 - take6);
          left_next   = take6;
          load_out    = (take6 == '0);
        end
        urb_pkg::MODE_HOST_WRITE: begin
          load_out = 1'b1;
          if (tx_wptr_inc != tx_rptr) begin
            tx_we        = 1'b1;
            tx_wptr_next = tx_wptr_inc;
            wa_next      = 1'b1;
            // An idle transmitter has an empty ring, so the new byte goes out now.
            if (!tx_active) begin
              tx_active_next = 1'b1;
              tx_rptr_next   = tx_wptr_inc;
              lb_next        = item_byte;
              lv_next        = 1'b1;
            end
          end
        end
        urb_pkg::MODE_TX_EMPTY: begin
          load_out = 1'b1;
          if (tx_wptr != tx_rptr) begin
            tx_rptr_next = tx_rptr_inc;
            lb_next      = tx_q;
            lv_next      = 1'b1;
          end else begin
            tx_active_next = 1'b0;
          end
        end
        default: begin
          load_out = 1'b1;
        end
      endcase
    end else if (cmd.step) begin
      load_out     = 1'b1;
      rb_next      = rx_q;
      rv_next      = 1'b1;
      last_next    = (left == urb_pkg::COUNT_W'(1));
      rx_rptr_next = rx_rptr_inc;
      left_next    = left - urb_pkg::COUNT_W'(1);
    end
  end

  // Control state: pointers, fill, transmit flag, burst count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wptr   <= '0;
      rx_rptr   <= '0;
      rx_cnt    <= '0;
      tx_wptr   <= '0;
      tx_rptr   <= '0;
      tx_active <= 1'b0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      rx_wptr   <= rx_wptr_next;
      rx_rptr   <= rx_rptr_next;
      rx_cnt    <= rx_cnt_next;
      tx_wptr   <= tx_wptr_next;
      tx_rptr   <= tx_rptr_next;
      tx_active <= tx_active_next;
      left      <= left_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode  <= urb_pkg::mode_t'(in_mode);
      item_byte  <= in_byte;
      item_count <= in_count;
    end
    if (load_out) begin
      out_read_byte      <= rb_next;
      out_read_valid     <= rv_next;
      out_last           <= last_next;
      out_line_byte      <= lb_next;
      out_line_valid     <= lv_next;
      out_write_accepted <= wa_next;
      out_rx_available   <= urb_pkg::COUNT_W'(rx_cnt_next);
    end
  end

  // Receive store; the read port always follows the next read pointer.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wptr] <= item_byte;
    end
    rx_q <= rx_mem[rx_rptr_next];
  end

  // Transmit store, read the same way.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wptr] <= item_byte;
    end
    tx_q <= tx_mem[tx_rptr_next];
  end

endmodule
